### src/rgb_rop_pkg.sv
// Shared types, constants and channel helpers for the RGB565 raster operation unit.
`default_nettype none
package rgb_rop_pkg;

  localparam int unsigned PixW     = 16;
  localparam int unsigned FadeW    = 11;
  localparam int unsigned ModeW    = 3;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;

  // Raster operation codes; the two unused codes leave the destination alone.
  typedef enum logic [ModeW-1:0] {
    MODE_COPY    = 3'd0,
    MODE_KEYED   = 3'd1,
    MODE_BLEND   = 3'd2,
    MODE_FADE    = 3'd3,
    MODE_AVERAGE = 3'd4,
    MODE_CLEAR   = 3'd5
  } mode_e;

  // Register indexes on the configuration channel.
  localparam logic [CfgIdxW-1:0] CFG_FADE_FACTOR = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_KEY_COLOR   = 2'd1;

  localparam logic [FadeW-1:0] FADE_ONE  = 11'd1024;
  localparam logic [PixW-1:0]  KEY_RESET = 16'h07E0;

  // Word held after the front stage.
  typedef struct packed {
    logic [ModeW-1:0] mode;
    logic [PixW-1:0]  src;
    logic [PixW-1:0]  dst;
    logic [FadeW-1:0] fade;
    logic             key_hit;
  } s1_t;

  // Word held after the arithmetic stage.
  typedef struct packed {
    logic [ModeW-1:0] mode;
    logic [PixW-1:0]  src;
    logic [PixW-1:0]  dst;
    logic             key_hit;
    logic [PixW-1:0]  blend;
    logic [PixW-1:0]  average;
    logic [15:0]      fade_r;
    logic [15:0]      fade_g;
    logic [15:0]      fade_b;
  } s2_t;

  // Result word.
  typedef struct packed {
    logic [PixW-1:0] result_pixel;
    logic            write_enable;
  } res_t;

  // (S*8 >> 5) + (D*24 >> 5) on a 5-bit channel: S/4 + 3D/4.
  function automatic logic [4:0] quarter_mix5(input logic [4:0] s, input logic [4:0] d);
    logic [6:0] d3;
    d3 = {2'b00, d} + {1'b0, d, 1'b0};
    return {2'b00, s[4:2]} + d3[6:2];
  endfunction

  // Same blend on the 6-bit green channel.
  function automatic logic [5:0] quarter_mix6(input logic [5:0] s, input logic [5:0] d);
    logic [7:0] d3;
    d3 = {2'b00, d} + {1'b0, d, 1'b0};
    return {2'b00, s[5:2]} + d3[7:2];
  endfunction

endpackage
`default_nettype wire

### src/rgb_rop_if.sv
// Valid/ready channel interfaces: pixel operation in, result out, configuration write.
`default_nettype none
interface rgb_rop_in_if;
  import rgb_rop_pkg::*;
  logic             valid;
  logic             ready;
  logic [ModeW-1:0] mode;
  logic [PixW-1:0]  src_pixel;
  logic [PixW-1:0]  dst_pixel;
  modport source (output valid, mode, src_pixel, dst_pixel, input ready);
  modport sink   (input valid, mode, src_pixel, dst_pixel, output ready);
endinterface

interface rgb_rop_out_if;
  import rgb_rop_pkg::*;
  logic            valid;
  logic            ready;
  logic [PixW-1:0] result_pixel;
  logic            write_enable;
  modport source (output valid, result_pixel, write_enable, input ready);
  modport sink   (input valid, result_pixel, write_enable, output ready);
endinterface

interface rgb_rop_cfg_if;
  import rgb_rop_pkg::*;
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

### src/rgb565_raster_op_unit.sv
// Top level of the RGB565 raster operation unit: config registers and three-stage pipeline.
// Streaming per-pixel raster operation on RGB565 words. Each input word carries a
// mode, a source and a destination pixel; each produces exactly one result word
// (new destination pixel plus write enable) from the stage 3 register, in order.
// One word is taken per clock as long as the sink keeps ready high; the rate is set
// by the three register stages (key compare and fade clamp, the 6x11 fade
// multipliers with blend/average adders, and the mode select), each of which holds
// its word while the stage after it is full and stalled. The configuration channel
// is always ready; write fade_factor (index 0) and key_color (index 1) only while
// no word is in flight. A fade factor above 1024 acts as 1024.
`default_nettype none
module rgb565_raster_op_unit (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  rgb_rop_cfg_if.sink  cfg_i,
  rgb_rop_in_if.sink   in_i,
  rgb_rop_out_if.source out_o
);
  import rgb_rop_pkg::*;

  logic [FadeW-1:0] fade_factor_q;
  logic [PixW-1:0]  key_color_q;

  logic s1_valid, s1_ready;
  logic s2_valid, s2_ready;
  logic s3_ready;
  s1_t  s1_word;
  s2_t  s2_word;
  res_t s3_word;

  // Configuration registers: accept every write, ignore unknown indexes.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fade_factor_q <= FADE_ONE;
      key_color_q   <= KEY_RESET;
    end else if (cfg_i.valid) begin
      if (cfg_i.index == CFG_FADE_FACTOR) begin
        fade_factor_q <= cfg_i.data[FadeW-1:0];
      end
      if (cfg_i.index == CFG_KEY_COLOR) begin
        key_color_q <= cfg_i.data;
      end
    end
  end

  // Stage 1: capture, clamp, key compare.
  rgb_rop_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (in_i.valid),
    .ready_o       (in_i.ready),
    .mode_i        (in_i.mode),
    .src_i         (in_i.src_pixel),
    .dst_i         (in_i.dst_pixel),
    .fade_factor_i (fade_factor_q),
    .key_color_i   (key_color_q),
    .valid_o       (s1_valid),
    .ready_i       (s2_ready),
    .word_o        (s1_word)
  );

  // Stage 2: multiply and add per channel.
  rgb_rop_arith u_arith (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s1_valid),
    .ready_o (s2_ready),
    .word_i  (s1_word),
    .valid_o (s2_valid),
    .ready_i (s3_ready),
    .word_o  (s2_word)
  );

  // Stage 3: select by mode; this register drives the output channel.
  rgb_rop_pack u_pack (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s2_valid),
    .ready_o (s3_ready),
    .word_i  (s2_word),
    .valid_o (out_o.valid),
    .ready_i (out_o.ready),
    .word_o  (s3_word)
  );

  assign out_o.result_pixel = s3_word.result_pixel;
  assign out_o.write_enable = s3_word.write_enable;

  assign s1_ready = s2_ready;

  // An accepted word always lands in stage 1.
  a_accept_fills_s1 : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> s1_valid)
    else $error("accepted word missing from stage 1");

  // A stalled stage 1 holds its word.
  a_s1_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid && !s1_ready) |=> (s1_valid && $stable(s1_word)))
    else $error("stage 1 word lost during stall");

  // A stalled stage 2 holds its word.
  a_s2_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_valid && !s3_ready) |=> (s2_valid && $stable(s2_word)))
    else $error("stage 2 word lost during stall");

endmodule
`default_nettype wire

### src/rgb_rop_front.sv
// Front stage: capture the word, saturate the fade factor, compare against the key.
`default_nettype none
module rgb_rop_front (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          valid_i,
  output logic                               ready_o,
  input  wire logic [rgb_rop_pkg::ModeW-1:0] mode_i,
  input  wire logic [rgb_rop_pkg::PixW-1:0]  src_i,
  input  wire logic [rgb_rop_pkg::PixW-1:0]  dst_i,
  input  wire logic [rgb_rop_pkg::FadeW-1:0] fade_factor_i,
  input  wire logic [rgb_rop_pkg::PixW-1:0]  key_color_i,
  output logic                               valid_o,
  input  wire logic                          ready_i,
  output rgb_rop_pkg::s1_t                   word_o
);
  import rgb_rop_pkg::*;

  logic valid_q;
  logic en;
  s1_t  word_d, word_q;

  assign en      = !valid_q || ready_i;
  assign ready_o = en;

  always_comb begin
    word_d.mode    = mode_i;
    word_d.src     = src_i;
    word_d.dst     = dst_i;
    // anything at or above one saturates to one
    word_d.fade    = fade_factor_i[FadeW-1] ? FADE_ONE : fade_factor_i;
    word_d.key_hit = (src_i == key_color_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && valid_i) begin
      word_q <= word_d;
    end
  end

  assign valid_o = valid_q;
  assign word_o  = word_q;
endmodule
`default_nettype wire

### src/rgb_rop_arith.sv
// Arithmetic stage: fade products, quarter blend and half average per channel.
`default_nettype none
module rgb_rop_arith (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             valid_i,
  output logic                  ready_o,
  input  wire rgb_rop_pkg::s1_t word_i,
  output logic                  valid_o,
  input  wire logic             ready_i,
  output rgb_rop_pkg::s2_t      word_o
);
  import rgb_rop_pkg::*;

  logic valid_q;
  logic en;
  s2_t  word_d, word_q;

  assign en      = !valid_q || ready_i;
  assign ready_o = en;

  always_comb begin
    word_d.mode    = word_i.mode;
    word_d.src     = word_i.src;
    word_d.dst     = word_i.dst;
    word_d.key_hit = word_i.key_hit;
    word_d.blend   = {quarter_mix5(word_i.src[15:11], word_i.dst[15:11]),
                      quarter_mix6(word_i.src[10:5],  word_i.dst[10:5]),
                      quarter_mix5(word_i.src[4:0],   word_i.dst[4:0])};
    word_d.average = {{1'b0, word_i.src[15:12]} + {1'b0, word_i.dst[15:12]},
                      {1'b0, word_i.src[10:6]}  + {1'b0, word_i.dst[10:6]},
                      {1'b0, word_i.src[4:1]}   + {1'b0, word_i.dst[4:1]}};
    // fade scales the destination only
    word_d.fade_r  = {11'd0, word_i.dst[15:11]} * {5'd0, word_i.fade};
    word_d.fade_g  = {10'd0, word_i.dst[10:5]}  * {5'd0, word_i.fade};
    word_d.fade_b  = {11'd0, word_i.dst[4:0]}   * {5'd0, word_i.fade};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && valid_i) begin
      word_q <= word_d;
    end
  end

  assign valid_o = valid_q;
  assign word_o  = word_q;
endmodule
`default_nettype wire

### src/rgb_rop_pack.sv
// Output stage: select the result for the mode and hold it for the sink.
`default_nettype none
module rgb_rop_pack (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             valid_i,
  output logic                  ready_o,
  input  wire rgb_rop_pkg::s2_t word_i,
  output logic                  valid_o,
  input  wire logic             ready_i,
  output rgb_rop_pkg::res_t     word_o
);
  import rgb_rop_pkg::*;

  logic valid_q;
  logic en;
  res_t word_d, word_q;

  assign en      = !valid_q || ready_i;
  assign ready_o = en;

  always_comb begin
    unique case (word_i.mode)
      MODE_COPY: begin
        word_d.result_pixel = word_i.src;
        word_d.write_enable = 1'b1;
      end
      MODE_KEYED: begin
        word_d.result_pixel = word_i.key_hit ? word_i.dst : word_i.src;
        word_d.write_enable = !word_i.key_hit;
      end
      MODE_BLEND: begin
        word_d.result_pixel = word_i.blend;
        word_d.write_enable = 1'b1;
      end
      MODE_FADE: begin
        // drop the ten fraction bits; products never pass the channel range
        word_d.result_pixel = {word_i.fade_r[14:10], word_i.fade_g[15:10],
                               word_i.fade_b[14:10]};
        word_d.write_enable = 1'b1;
      end
      MODE_AVERAGE: begin
        word_d.result_pixel = word_i.average;
        word_d.write_enable = 1'b1;
      end
      MODE_CLEAR: begin
        word_d.result_pixel = '0;
        word_d.write_enable = 1'b1;
      end
      default: begin
        word_d.result_pixel = word_i.dst;
        word_d.write_enable = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && valid_i) begin
      word_q <= word_d;
    end
  end

  assign valid_o = valid_q;
  assign word_o  = word_q;
endmodule
`default_nettype wire
